[rtl/core/indexed_bitmap_set_with_count_top_defines.svh]
// ----------------------------------------------------------------------------
// indexed bitmap set assertion macros
// shared concurrent assertion forms for the bitmap set core
// ----------------------------------------------------------------------------
`ifndef INDEXED_BITMAP_SET_WITH_COUNT_TOP_DEFINES_SVH
`define INDEXED_BITMAP_SET_WITH_COUNT_TOP_DEFINES_SVH

// same-cycle implication
`define IBS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibs assertion failed");

// next-cycle implication
`define IBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibs assertion failed");

`endif

[rtl/core/ibs_pkg.sv]
// ----------------------------------------------------------------------------
// ibs_pkg
// types, function codes and row geometry of the bitmap set core
// ----------------------------------------------------------------------------
package ibs_pkg;

   localparam int DEF_TABLE_ENTRIES = 512;
   localparam int ROW_BITS          = 32;
   localparam int POS_W             = $clog2(ROW_BITS);

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_TEST   = 3'd2;
   localparam logic [2:0] FUNC_COUNT  = 3'd3;
   localparam logic [2:0] FUNC_LIST   = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [9:0] entry_index;
      logic [5:0] max_count;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [9:0]  member_index;
      logic        is_member;
      logic [10:0] reply_count;
      logic        last_item;
   } rsp_type;

   typedef struct packed {
      logic             find;
      logic [POS_W-1:0] pos;
   } bit_op_type;

   typedef struct packed {
      logic                hit;
      logic [POS_W-1:0]    pos;
      logic [ROW_BITS-1:0] word_set;
      logic [ROW_BITS-1:0] word_clr;
   } bit_res_type;

endpackage

[rtl/core/ibs_bit_unit.sv]
// ----------------------------------------------------------------------------
// ibs_bit_unit
// shared row bit unit: selects a bit by position or finds the lowest set bit,
// and returns the row with that bit set and cleared
// ----------------------------------------------------------------------------
module ibs_bit_unit (
   input  logic [ibs_pkg::ROW_BITS-1:0] row_word,
   input  ibs_pkg::bit_op_type          op,
   output ibs_pkg::bit_res_type         res
);

   logic [ibs_pkg::ROW_BITS-1:0] mask;
   logic [ibs_pkg::POS_W-1:0]    pos_enc;

   always_comb begin
      if (op.find) begin
         mask = row_word & (~row_word + ibs_pkg::ROW_BITS'(1));
      end else begin
         mask = ibs_pkg::ROW_BITS'(1) << op.pos;
      end
   end

   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < ibs_pkg::ROW_BITS; i++) begin
         if (mask[i]) begin
            pos_enc = pos_enc | ibs_pkg::POS_W'(i);
         end
      end
   end

   assign res.hit      = |(row_word & mask);
   assign res.pos      = pos_enc;
   assign res.word_set = row_word | mask;
   assign res.word_clr = row_word & ~mask;

endmodule

[rtl/core/ibs_row_mem.sv]
// ----------------------------------------------------------------------------
// ibs_row_mem
// membership bitmap store, one row of bits per address, registered read,
// per-row valid flags so a never-written row reads as zero after reset
// ----------------------------------------------------------------------------
module ibs_row_mem #(
   parameter int ROWS = ibs_pkg::DEF_TABLE_ENTRIES / ibs_pkg::ROW_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(ROWS)-1:0]      rd_addr,
   output logic [ibs_pkg::ROW_BITS-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(ROWS)-1:0]      wr_addr,
   input  logic [ibs_pkg::ROW_BITS-1:0] wr_data
);

   logic [ibs_pkg::ROW_BITS-1:0] mem_ff [ROWS];
   logic [ibs_pkg::ROW_BITS-1:0] rd_data_ff;
   logic                         rd_ok_ff;
   logic [ROWS-1:0]              row_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_ok_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

[rtl/core/indexed_bitmap_set_with_count_top.sv]
// ----------------------------------------------------------------------------
// channel | role   | handshake          | word
// req     | input  | req_valid/req_stall | ibs_pkg::req_type
// rsp     | output | rsp_valid/rsp_stall | ibs_pkg::rsp_type
//
// add, remove, test in range: row read, update through the bit unit, reply
// count, undefined codes and out of range indices: reply straight from idle
// list: loads each row, then lists its members one at a time until the row is empty
//   or the limit is reached, paced by the row memory read port
// reset clears the per-row valid flags at once, no clearing pass
// a stalled rsp holds the sequencer; req is taken only when it is idle
// ----------------------------------------------------------------------------
// indexed_bitmap_set_with_count_top
// membership bitmap with member count, one shared bit unit under a sequencer
// ----------------------------------------------------------------------------
`include "indexed_bitmap_set_with_count_top_defines.svh"

module indexed_bitmap_set_with_count_top #(
   parameter int TABLE_ENTRIES = ibs_pkg::DEF_TABLE_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ibs_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ibs_pkg::rsp_type rsp_word
);

   localparam int ROWS  = (TABLE_ENTRIES + ibs_pkg::ROW_BITS - 1) / ibs_pkg::ROW_BITS;
   localparam int RAW   = $clog2(ROWS);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RMW,
      S_REPLY,
      S_LLOAD,
      S_LSCAN
   } state_type;

   state_type                    state_ff;
   logic [2:0]                   func_ff;
   logic [ibs_pkg::POS_W-1:0]    pos_ff;
   logic [RAW-1:0]               row_ff;
   logic [5:0]                   limit_ff;
   logic [5:0]                   list_n_ff;
   logic [CNT_W-1:0]             total_ff;
   logic                         reply_mem_ff;
   logic [10:0]                  reply_cnt_ff;
   logic [ibs_pkg::ROW_BITS-1:0] scan_ff;
   logic                         rsp_valid_ff;
   ibs_pkg::rsp_type             rsp_word_ff;

   logic                         req_take;
   logic                         out_free;
   logic                         rsp_load;
   logic                         in_range;
   logic [RAW-1:0]               rd_addr;
   logic [ibs_pkg::ROW_BITS-1:0] rd_data;
   logic                         wr_en;
   logic [ibs_pkg::ROW_BITS-1:0] wr_data;
   logic [ibs_pkg::ROW_BITS-1:0] unit_word;
   ibs_pkg::bit_op_type          unit_op;
   ibs_pkg::bit_res_type         unit_res;
   logic [5:0]                   list_n_next;
   logic                         list_word_ok;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = out_free && ((state_ff == S_REPLY) ||
                                     ((state_ff == S_LSCAN) && unit_res.hit));
   assign in_range    = 11'(req_word.entry_index) < 11'(TABLE_ENTRIES);
   assign list_n_next = list_n_ff + 6'd1;

   // row address: request row when idle, next row while scanning
   always_comb begin
      if (state_ff == S_LSCAN) begin
         rd_addr = row_ff + RAW'(1);
      end else if (req_word.func == ibs_pkg::FUNC_LIST) begin
         rd_addr = '0;
      end else begin
         rd_addr = req_word.entry_index[ibs_pkg::POS_W +: RAW];
      end
   end

   assign wr_en   = (state_ff == S_RMW) &&
                    ((func_ff == ibs_pkg::FUNC_ADD) || (func_ff == ibs_pkg::FUNC_REMOVE));
   assign wr_data = (func_ff == ibs_pkg::FUNC_ADD) ? unit_res.word_set : unit_res.word_clr;

   assign unit_word   = (state_ff == S_LSCAN) ? scan_ff : rd_data;
   assign unit_op.find = (state_ff == S_LSCAN);
   assign unit_op.pos  = pos_ff;

   ibs_row_mem #(
      .ROWS (ROWS)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data)
   );

   ibs_bit_unit u_bit_unit (
      .row_word (unit_word),
      .op       (unit_op),
      .res      (unit_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  func_ff   <= req_word.func;
                  pos_ff    <= req_word.entry_index[ibs_pkg::POS_W-1:0];
                  row_ff    <= rd_addr;
                  limit_ff  <= req_word.max_count;
                  list_n_ff <= '0;
                  priority if (in_range && ((req_word.func == ibs_pkg::FUNC_ADD) ||
                                            (req_word.func == ibs_pkg::FUNC_REMOVE) ||
                                            (req_word.func == ibs_pkg::FUNC_TEST))) begin
                     state_ff <= S_RMW;
                  end else if ((req_word.func == ibs_pkg::FUNC_LIST) &&
                               (req_word.max_count != 6'd0)) begin
                     state_ff <= S_LLOAD;
                  end else if (req_word.func == ibs_pkg::FUNC_LIST) begin
                     reply_mem_ff <= 1'b0;
                     reply_cnt_ff <= '0;
                     state_ff     <= S_REPLY;
                  end else begin
                     reply_mem_ff <= 1'b0;
                     reply_cnt_ff <= 11'(total_ff);
                     state_ff     <= S_REPLY;
                  end
               end
            end
            S_RMW: begin
               unique case (func_ff)
                  ibs_pkg::FUNC_ADD: begin
                     reply_mem_ff <= 1'b1;
                     if (!unit_res.hit) begin
                        total_ff     <= total_ff + CNT_W'(1);
                        reply_cnt_ff <= 11'(total_ff + CNT_W'(1));
                     end else begin
                        reply_cnt_ff <= 11'(total_ff);
                     end
                  end
                  ibs_pkg::FUNC_REMOVE: begin
                     reply_mem_ff <= 1'b0;
                     if (unit_res.hit) begin
                        total_ff     <= total_ff - CNT_W'(1);
                        reply_cnt_ff <= 11'(total_ff - CNT_W'(1));
                     end else begin
                        reply_cnt_ff <= 11'(total_ff);
                     end
                  end
                  default: begin
                     reply_mem_ff <= unit_res.hit;
                     reply_cnt_ff <= 11'(total_ff);
                  end
               endcase
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               if (out_free) begin
                  rsp_word_ff.item_kind    <= 1'b0;
                  rsp_word_ff.member_index <= '0;
                  rsp_word_ff.is_member    <= reply_mem_ff;
                  rsp_word_ff.reply_count  <= reply_cnt_ff;
                  rsp_word_ff.last_item    <= 1'b1;
                  state_ff                 <= S_IDLE;
               end
            end
            S_LLOAD: begin
               scan_ff  <= rd_data;
               state_ff <= S_LSCAN;
            end
            S_LSCAN: begin
               if (!unit_res.hit) begin
                  if (row_ff == LAST_ROW) begin
                     reply_mem_ff <= 1'b0;
                     reply_cnt_ff <= 11'(list_n_ff);
                     state_ff     <= S_REPLY;
                  end else begin
                     row_ff   <= row_ff + RAW'(1);
                     state_ff <= S_LLOAD;
                  end
               end else if (out_free) begin
                  rsp_word_ff.item_kind    <= 1'b1;
                  rsp_word_ff.member_index <= 10'({row_ff, unit_res.pos});
                  rsp_word_ff.is_member    <= 1'b1;
                  rsp_word_ff.reply_count  <= '0;
                  rsp_word_ff.last_item    <= 1'b0;
                  scan_ff                  <= unit_res.word_clr;
                  list_n_ff                <= list_n_next;
                  if (list_n_next == limit_ff) begin
                     reply_mem_ff <= 1'b0;
                     reply_cnt_ff <= 11'(list_n_next);
                     state_ff     <= S_REPLY;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign list_word_ok = !rsp_word_ff.last_item && rsp_word_ff.is_member &&
                         (rsp_word_ff.reply_count == 11'd0);

   `IBS_ASSERT_IMPLIES(a_total_bound, clock, reset, 1'b1, (32'(total_ff) <= 32'(TABLE_ENTRIES)))
   `IBS_ASSERT_NEXT(a_total_step, clock, reset, 1'b1, ((total_ff - $past(total_ff) + CNT_W'(1)) <= CNT_W'(2)))
   `IBS_ASSERT_IMPLIES(a_scan_below_limit, clock, reset, (state_ff == S_LSCAN), (list_n_ff < limit_ff))
   `IBS_ASSERT_IMPLIES(a_list_word_shape, clock, reset, (rsp_valid_ff && rsp_word_ff.item_kind), list_word_ok)
   `IBS_ASSERT_NEXT(a_rmw_to_reply, clock, reset, (state_ff == S_RMW), (state_ff == S_REPLY))

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the bitmap set against a behavioral copy of its membership and count:
// a queued driver and a monitor with random gaps on both sides, a long
// response hold-off to back the core up, directed corner words, then random
// fill and drain traffic
// ----------------------------------------------------------------------------
module tb;

   localparam int TABLE_ENTRIES = ibs_pkg::DEF_TABLE_ENTRIES;
   localparam int RANDOM_WORDS  = 86;
   localparam int FILL_WORDS    = 62;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 40;
   localparam int IDLE_LIMIT    = 4000;
   localparam int TAIL_CYCLES   = 200;

   localparam logic [2:0] FUNC_RSVD_LO  = 3'd5;
   localparam logic [2:0] FUNC_RSVD_MID = 3'd6;
   localparam logic [2:0] FUNC_RSVD_HI  = 3'd7;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ibs_pkg::req_type req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ibs_pkg::rsp_type rsp_word;

   indexed_bitmap_set_with_count_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // membership copy and the words it says the core owes
   bit               member_set [TABLE_ENTRIES];
   int               member_cnt = 0;
   ibs_pkg::rsp_type due_words [$];
   ibs_pkg::req_type req_backlog [$];
   int               fault_count = 0;
   int               req_taken = 0;
   logic             quiet_run = 1'b0;

   function automatic int pick_gap(input logic quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic apply_request(input ibs_pkg::req_type w);
      ibs_pkg::rsp_type r;
      int               listed;
      int               i;
      logic             hit;
      logic             in_range;
      listed   = 0;
      hit      = 1'b0;
      in_range = w.entry_index < TABLE_ENTRIES;
      case (w.func)
         ibs_pkg::FUNC_ADD: begin
            if (in_range) begin
               if (!member_set[w.entry_index]) begin
                  member_set[w.entry_index] = 1'b1;
                  member_cnt++;
               end
               hit = 1'b1;
            end
         end
         ibs_pkg::FUNC_REMOVE: begin
            if (in_range && member_set[w.entry_index]) begin
               member_set[w.entry_index] = 1'b0;
               member_cnt--;
            end
         end
         ibs_pkg::FUNC_TEST: begin
            if (in_range)
               hit = member_set[w.entry_index];
         end
         ibs_pkg::FUNC_LIST: begin
            for (i = 0; i < TABLE_ENTRIES && listed < w.max_count; i++) begin
               if (member_set[i]) begin
                  r              = '0;
                  r.item_kind    = 1'b1;
                  r.member_index = i[9:0];
                  r.is_member    = 1'b1;
                  due_words.push_back(r);
                  listed++;
               end
            end
         end
         default: ;
      endcase
      r             = '0;
      r.is_member   = hit;
      r.reply_count = (w.func == ibs_pkg::FUNC_LIST) ? listed[10:0] : member_cnt[10:0];
      r.last_item   = 1'b1;
      due_words.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [10:0] want_v,
                              input logic [10:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fault_count++;
      end
   endtask

   task automatic queue_word(input logic [2:0] f, input logic [9:0] idx,
                             input logic [5:0] lim);
      ibs_pkg::req_type w;
      w.func        = f;
      w.entry_index = idx;
      w.max_count   = lim;
      req_backlog.push_back(w);
   endtask

   // alternating stretches with and without idling
   always @(posedge clock) begin
      int phase_left;
      if (phase_left == 0) begin
         quiet_run  <= !quiet_run;
         phase_left = quiet_run ? $urandom_range(150, 400) : $urandom_range(40, 120);
      end else begin
         phase_left--;
      end
   end

   // request driver
   always @(posedge clock) begin
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            apply_request(req_word);
            req_taken <= req_taken + 1;
         end
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (req_backlog.size() > 0) begin
            req_word  <= req_backlog.pop_front();
            req_valid <= 1'b1;
            gap_left  = pick_gap(quiet_run);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with one long hold-off while requests keep coming
   always @(posedge clock) begin
      int  stall_left;
      int  hold_left;
      bit  hold_done;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && req_taken >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES - 1;
         hold_done = 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = pick_gap(quiet_run);
      end
   end

   // response monitor
   always @(posedge clock) begin
      ibs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            $error("result word with nothing expected");
            fault_count++;
         end else begin
            want = due_words.pop_front();
            check_field("item_kind", 11'(want.item_kind), 11'(rsp_word.item_kind));
            check_field("member_index", 11'(want.member_index),
                        11'(rsp_word.member_index));
            check_field("is_member", 11'(want.is_member), 11'(rsp_word.is_member));
            check_field("reply_count", want.reply_count, rsp_word.reply_count);
            check_field("last_item", 11'(want.last_item), 11'(rsp_word.last_item));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("indexed_bitmap_set_with_count_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      int          n;
      int          roll;
      int          add_cut;
      int          rem_cut;
      int          queued_total;
      logic [2:0]  f;
      logic [9:0]  idx;
      logic [5:0]  lim;
      logic [9:0]  added [$];

      // directed corners
      queue_word(ibs_pkg::FUNC_COUNT, 10'd0, 6'd0);
      queue_word(ibs_pkg::FUNC_LIST, 10'd0, 6'd63);
      queue_word(ibs_pkg::FUNC_TEST, 10'd0, 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, 10'd0, 6'd63);
      queue_word(ibs_pkg::FUNC_ADD, 10'd0, 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, 10'(TABLE_ENTRIES - 1), 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, 10'(TABLE_ENTRIES), 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, '1, '1);
      queue_word(ibs_pkg::FUNC_TEST, '1, 6'd0);
      queue_word(ibs_pkg::FUNC_TEST, 10'(TABLE_ENTRIES - 1), 6'd0);
      queue_word(ibs_pkg::FUNC_REMOVE, '1, 6'd0);
      queue_word(ibs_pkg::FUNC_REMOVE, 10'd5, 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, 10'd5, 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, 10'd300, 6'd0);
      queue_word(ibs_pkg::FUNC_ADD, 10'd170, 6'd0);
      queue_word(ibs_pkg::FUNC_LIST, '1, 6'd0);
      queue_word(ibs_pkg::FUNC_LIST, 10'd0, 6'd2);
      queue_word(ibs_pkg::FUNC_LIST, 10'd0, 6'd63);
      queue_word(FUNC_RSVD_LO, 10'd5, 6'd7);
      queue_word(FUNC_RSVD_MID, '1, '1);
      queue_word(FUNC_RSVD_HI, 10'd0, 6'd0);
      queue_word(ibs_pkg::FUNC_REMOVE, 10'd0, 6'd0);
      queue_word(ibs_pkg::FUNC_REMOVE, 10'(TABLE_ENTRIES - 1), 6'd0);
      queue_word(ibs_pkg::FUNC_COUNT, 10'd5, 6'd1);

      // random fill then drain, removes and tests mostly aimed at members
      for (n = 0; n < RANDOM_WORDS; n++) begin
         roll    = $urandom_range(0, 99);
         add_cut = (n < FILL_WORDS) ? 72 : 30;
         rem_cut = add_cut + ((n < FILL_WORDS) ? 8 : 30);
         if ($urandom_range(0, 9) == 0)
            idx = 10'($urandom_range(TABLE_ENTRIES, 1023));
         else
            idx = 10'($urandom_range(0, TABLE_ENTRIES - 1));
         lim = ($urandom_range(0, 3) == 0) ? 6'd63 : 6'($urandom_range(0, 63));
         if (roll < add_cut) begin
            f = ibs_pkg::FUNC_ADD;
            added.push_back(idx);
         end else if (roll < rem_cut) begin
            f = ibs_pkg::FUNC_REMOVE;
         end else if (roll < rem_cut + 10) begin
            f = ibs_pkg::FUNC_TEST;
         end else if (roll < rem_cut + 14) begin
            f = ibs_pkg::FUNC_COUNT;
         end else if (roll < 97) begin
            f = ibs_pkg::FUNC_LIST;
         end else begin
            f = 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
         end
         if ((f == ibs_pkg::FUNC_REMOVE || f == ibs_pkg::FUNC_TEST) && added.size() > 0
             && $urandom_range(0, 9) < 7)
            idx = added[$urandom_range(0, added.size() - 1)];
         queue_word(f, idx, lim);
      end
      queued_total = req_backlog.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (req_taken < queued_total || due_words.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0 && due_words.size() == 0)
         $display("indexed_bitmap_set_with_count_top verification clean");
      else
         $display("indexed_bitmap_set_with_count_top verification failed");
      $finish;
   end

endmodule
